// ----- design/fsgs_pkg.sv -----
// Shared constants, operation codes and the random generator for the sand grid stepper.
package fsgs_pkg;

  localparam int GRID_WIDTH_DEF  = 128;
  localparam int GRID_HEIGHT_DEF = 128;
  localparam int LIST_DEPTH_DEF  = 16384;

  localparam int          COUNT_MAX   = 32767;
  localparam logic [31:0] RANDOM_SEED = 32'h1234_5678;

  localparam logic [1:0] OP_PLACE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // xorshift32: shifts 13, 17, 5
  function automatic logic [31:0] xorshift32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    a = v ^ (v << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

// ----- design/fsgs_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port.
module fsgs_ram #(
  parameter int DW = 1,
  parameter int AW = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/falling_sand_grid_step.sv -----
// Top level: falling sand grid stepper with its sequencer and memories.
//
//  channel   direction  handshake              fields
//  command   in         start_i && !busy_o     operation_i, col_x_i, row_y_i
//  result    out        done_o (one cycle)     cell_value_o, moved_count_o,
//                                              active_count_o, list_overflow_o
//
// Read: returns the addressed cell in cell_value_o. Place: writes the cell,
// then wakes each neighbor inside the grid above the bottom row. Clear: writes
// one cell of the 2^(XW+YW) address space per cycle. Step: per list entry
// fetches it, tests the cell, below and one diagonal; a moved grain writes both
// cells and wakes both neighborhoods. One sequencer drives grid, mark and list.
// After reset the same pass clears grid and marks with busy_o high. Each
// result shows for one cycle on done_o; the receiver cannot stall.
module falling_sand_grid_step import fsgs_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter int LIST_DEPTH  = LIST_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [6:0]  col_x_i,
  input  logic [6:0]  row_y_i,
  output logic        done_o,
  output logic        cell_value_o,
  output logic [14:0] moved_count_o,
  output logic [14:0] active_count_o,
  output logic        list_overflow_o
);

  localparam int XW = $clog2(GRID_WIDTH);
  localparam int YW = $clog2(GRID_HEIGHT);
  localparam int AW = XW + YW;
  localparam int IW = $clog2(LIST_DEPTH);
  localparam int LW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ_W, S_FETCH, S_ENTRY, S_CELL, S_BELOW, S_DIAG,
    S_WRITE, S_WAKE_RD, S_WAKE_WR
  } state_e;

  typedef enum logic [1:0] {AFT_DONE, AFT_MOVE2, AFT_NEXT} after_e;

  state_e        state_q, state_d;
  after_e        aft_q, aft_d;
  logic [XW-1:0] x_q, x_d, tx_q, tx_d, wx_q, wx_d;
  logic [YW-1:0] y_q, y_d, ty_q, ty_d, wy_q, wy_d;
  logic          wv_q, wv_d;
  logic [1:0]    dx_q, dx_d, dy_q, dy_d;
  logic [AW-1:0] nadr_q, nadr_d, clr_q, clr_d;
  logic          bank_q, bank_d;
  logic [LW-1:0] cur_len_q, cur_len_d, next_len_q, next_len_d, k_q, k_d;
  logic [LW-1:0] moved_q, moved_d;
  logic [31:0]   rnd_q, rnd_d;
  logic          drop_q, drop_d, pend_q, pend_d, val_q, val_d, done_q, done_d;

  logic          grid_we, grid_wd, grid_rd;
  logic [AW-1:0] grid_wa, grid_ra;
  logic          mark_we, mark_wd, mark_rd;
  logic [AW-1:0] mark_wa, mark_ra;
  logic          list_we;
  logic [IW:0]   list_wa, list_ra;
  logic [AW-1:0] list_wd, list_rd;

  logic signed [XW+1:0] nx;
  logic signed [YW+1:0] ny;
  logic                 n_ok;
  logic [31:0]          rnd_next;
  logic                 in_grid;

  fsgs_ram #(.DW(1), .AW(AW)) u_grid (
    .clk_i, .we_i(grid_we), .waddr_i(grid_wa), .wdata_i(grid_wd),
    .raddr_i(grid_ra), .rdata_o(grid_rd)
  );

  fsgs_ram #(.DW(1), .AW(AW)) u_mark (
    .clk_i, .we_i(mark_we), .waddr_i(mark_wa), .wdata_i(mark_wd),
    .raddr_i(mark_ra), .rdata_o(mark_rd)
  );

  fsgs_ram #(.DW(AW), .AW(IW + 1)) u_list (
    .clk_i, .we_i(list_we), .waddr_i(list_wa), .wdata_i(list_wd),
    .raddr_i(list_ra), .rdata_o(list_rd)
  );

  function automatic logic [14:0] sat15(input logic [LW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'(COUNT_MAX)) ? 15'(COUNT_MAX) : w[14:0];
  endfunction

  assign nx = $signed({2'b00, wx_q}) + $signed({{XW{1'b0}}, dx_q}) - $signed((XW+2)'(1));
  assign ny = $signed({2'b00, wy_q}) + $signed({{YW{1'b0}}, dy_q}) - $signed((YW+2)'(1));
  // bottom row never enters the list
  assign n_ok = !nx[XW+1] && (nx < $signed((XW+2)'(GRID_WIDTH))) &&
                !ny[YW+1] && (ny < $signed((YW+2)'(GRID_HEIGHT - 1)));
  assign rnd_next = xorshift32(rnd_q);
  assign in_grid = (32'(col_x_i) < 32'(GRID_WIDTH)) && (32'(row_y_i) < 32'(GRID_HEIGHT));

  always_comb begin
    state_d = state_q; aft_d = aft_q;
    x_d = x_q; y_d = y_q; tx_d = tx_q; ty_d = ty_q; wx_d = wx_q; wy_d = wy_q;
    wv_d = wv_q; dx_d = dx_q; dy_d = dy_q; nadr_d = nadr_q; clr_d = clr_q;
    bank_d = bank_q; cur_len_d = cur_len_q; next_len_d = next_len_q; k_d = k_q;
    moved_d = moved_q; rnd_d = rnd_q; drop_d = drop_q; pend_d = pend_q;
    val_d = val_q; done_d = 1'b0;
    grid_we = 1'b0; grid_wa = '0; grid_wd = 1'b0; grid_ra = '0;
    mark_we = 1'b0; mark_wa = '0; mark_wd = 1'b0; mark_ra = '0;
    list_we = 1'b0; list_wa = '0; list_wd = '0; list_ra = '0;

    case (state_q)
      S_CLEAR: begin
        grid_we = 1'b1; grid_wa = clr_q;
        mark_we = 1'b1; mark_wa = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == {AW{1'b1}}) begin
          state_d = S_IDLE;
          done_d = pend_q;
          pend_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          drop_d = 1'b0; val_d = 1'b0; moved_d = '0;
          x_d = XW'(col_x_i); y_d = YW'(row_y_i);
          case (operation_i)
            OP_PLACE: begin
              if (in_grid) begin
                wx_d = XW'(col_x_i); wy_d = YW'(row_y_i); wv_d = 1'b1;
                aft_d = AFT_DONE; state_d = S_WRITE;
              end else begin
                done_d = 1'b1;
              end
            end
            OP_STEP: begin
              bank_d = ~bank_q; cur_len_d = next_len_q; next_len_d = '0;
              k_d = '0; state_d = S_FETCH;
            end
            OP_READ: begin
              if (in_grid) begin
                grid_ra = {YW'(row_y_i), XW'(col_x_i)};
                state_d = S_READ_W;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              cur_len_d = '0; next_len_d = '0; clr_d = '0;
              pend_d = 1'b1; state_d = S_CLEAR;
            end
          endcase
        end
      end
      S_READ_W: begin
        val_d = grid_rd; done_d = 1'b1; state_d = S_IDLE;
      end
      S_FETCH: begin
        if (k_q == cur_len_q) begin
          done_d = 1'b1; state_d = S_IDLE;
        end else begin
          list_ra = {bank_q, k_q[IW-1:0]};
          state_d = S_ENTRY;
        end
      end
      S_ENTRY: begin
        {y_d, x_d} = list_rd;
        mark_we = 1'b1; mark_wa = list_rd;
        grid_ra = list_rd;
        state_d = S_CELL;
      end
      S_CELL: begin
        if (!grid_rd || (y_q == YW'(GRID_HEIGHT - 1))) begin
          k_d = k_q + LW'(1); state_d = S_FETCH;
        end else begin
          grid_ra = {y_q + YW'(1), x_q};
          state_d = S_BELOW;
        end
      end
      S_BELOW: begin
        ty_d = y_q + YW'(1);
        if (!grid_rd) begin
          tx_d = x_q;
          wx_d = x_q; wy_d = y_q; wv_d = 1'b0; aft_d = AFT_MOVE2;
          state_d = S_WRITE;
        end else begin
          rnd_d = rnd_next;
          if (rnd_next[0]) begin
            if (x_q != '0) begin
              tx_d = x_q - XW'(1);
              grid_ra = {y_q + YW'(1), x_q - XW'(1)};
              state_d = S_DIAG;
            end else begin
              k_d = k_q + LW'(1); state_d = S_FETCH;
            end
          end else begin
            if (x_q != XW'(GRID_WIDTH - 1)) begin
              tx_d = x_q + XW'(1);
              grid_ra = {y_q + YW'(1), x_q + XW'(1)};
              state_d = S_DIAG;
            end else begin
              k_d = k_q + LW'(1); state_d = S_FETCH;
            end
          end
        end
      end
      S_DIAG: begin
        if (!grid_rd) begin
          wx_d = x_q; wy_d = y_q; wv_d = 1'b0; aft_d = AFT_MOVE2;
          state_d = S_WRITE;
        end else begin
          k_d = k_q + LW'(1); state_d = S_FETCH;
        end
      end
      S_WRITE: begin
        grid_we = 1'b1; grid_wa = {wy_q, wx_q}; grid_wd = wv_q;
        dx_d = '0; dy_d = '0; state_d = S_WAKE_RD;
      end
      S_WAKE_RD, S_WAKE_WR: begin
        if (state_q == S_WAKE_RD && n_ok) begin
          mark_ra = {ny[YW-1:0], nx[XW-1:0]};
          nadr_d = {ny[YW-1:0], nx[XW-1:0]};
          state_d = S_WAKE_WR;
        end else begin
          if (state_q == S_WAKE_WR && !mark_rd) begin
            if (next_len_q >= LW'(LIST_DEPTH)) begin
              drop_d = 1'b1;
            end else begin
              mark_we = 1'b1; mark_wa = nadr_q; mark_wd = 1'b1;
              list_we = 1'b1; list_wa = {~bank_q, next_len_q[IW-1:0]};
              list_wd = nadr_q;
              next_len_d = next_len_q + LW'(1);
            end
          end
          // advance over the 3x3 neighborhood
          state_d = S_WAKE_RD;
          if (dx_q == 2'd2) begin
            dx_d = '0;
            if (dy_q == 2'd2) begin
              case (aft_q)
                AFT_DONE: begin
                  done_d = 1'b1; state_d = S_IDLE;
                end
                AFT_MOVE2: begin
                  wx_d = tx_q; wy_d = ty_q; wv_d = 1'b1; aft_d = AFT_NEXT;
                  state_d = S_WRITE;
                end
                default: begin
                  moved_d = moved_q + LW'(1); k_d = k_q + LW'(1);
                  state_d = S_FETCH;
                end
              endcase
            end else begin
              dy_d = dy_q + 2'd1;
            end
          end else begin
            dx_d = dx_q + 2'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; aft_q <= AFT_DONE; clr_q <= '0; bank_q <= 1'b0;
      cur_len_q <= '0; next_len_q <= '0; k_q <= '0; moved_q <= '0;
      rnd_q <= RANDOM_SEED; drop_q <= 1'b0; pend_q <= 1'b0; val_q <= 1'b0;
      done_q <= 1'b0; dx_q <= '0; dy_q <= '0;
    end else begin
      state_q <= state_d; aft_q <= aft_d; clr_q <= clr_d; bank_q <= bank_d;
      cur_len_q <= cur_len_d; next_len_q <= next_len_d; k_q <= k_d;
      moved_q <= moved_d; rnd_q <= rnd_d; drop_q <= drop_d; pend_q <= pend_d;
      val_q <= val_d; done_q <= done_d; dx_q <= dx_d; dy_q <= dy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; tx_q <= tx_d; ty_q <= ty_d;
    wx_q <= wx_d; wy_q <= wy_d; wv_q <= wv_d; nadr_q <= nadr_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign cell_value_o    = val_q;
  assign moved_count_o   = sat15(moved_q);
  assign active_count_o  = sat15(next_len_q);
  assign list_overflow_o = drop_q;

endmodule
